// ----- rtl/vlmk_pkg.sv -----
// Shared constants, codes and types of the VOX level meter keyer.
package vlmk_pkg;

  localparam int BLOCK_SAMPLES = 2048;
  localparam int FRAME_MS      = 16;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 8;
  localparam int LEVEL_W    = 8;
  localparam int MS_W       = 14;
  localparam int TIMER_W    = 16;
  localparam int SUM_W      = 36;
  localparam int CNT_W      = $clog2(BLOCK_SAMPLES + 1);
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Divider widths: den = 640 * count, divisor = 2 * den, dividend = 2 * sum + den.
  localparam int DEN_W = CNT_W + 10;
  localparam int DVS_W = DEN_W + 1;
  localparam int REM_W = SUM_W + 2;
  localparam int QUOT_W = LEVEL_W;
  localparam int STEP_W = $clog2(QUOT_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_PTT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VOX_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOX_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIC_GAIN   = 3'd4;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } block_job_t;

  typedef struct packed {
    logic tick;
    logic ptt;
  } item_cmd_t;

  typedef struct packed {
    logic               key_on;
    logic [LEVEL_W-1:0] meter;
  } result_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_CHECK,
    DIV_STEP,
    DIV_DONE
  } div_state_t;

endpackage

// ----- rtl/vlmk_front.sv -----
// Front end: classifies items, accumulates block sums and hands finished blocks on.
module vlmk_front import vlmk_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic [1:0]                 func,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       block_last,
  input  logic [GAIN_W-1:0]          gain,
  input  logic                       out_free,
  input  logic                       q_full,
  input  logic                       back_pending,
  output logic                       item_stall,
  output logic                       accept,
  output item_cmd_t                  cmd,
  output logic                       job_push,
  output block_job_t                 job
);

  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    count;
  logic [SAMPLE_W-1:0] mag;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]    count_inc;
  logic                block_end;
  logic                can_take;
  logic                is_sample;

  assign mag       = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
  assign prod      = PROD_W'(mag) * PROD_W'(gain);
  assign sum_add   = sum + SUM_W'(prod);
  assign count_inc = count + 1'b1;
  assign block_end = block_last || (count_inc >= CNT_W'(BLOCK_SAMPLES));
  assign is_sample = (func == FUNC_SAMPLE);

  // A frame tick must see the peak of every block that ended before it.
  always_comb begin
    case (func)
      FUNC_SAMPLE: can_take = !(block_end && q_full);
      FUNC_TICK:   can_take = !back_pending;
      default:     can_take = 1'b1;
    endcase
  end

  assign item_stall = !(out_free && can_take);
  assign accept     = item_valid && !item_stall;
  assign job_push   = accept && is_sample && block_end;
  assign job.sum    = sum_add;
  assign job.count  = count_inc;
  assign cmd.tick   = accept && (func == FUNC_TICK);
  assign cmd.ptt    = accept && (func == FUNC_PTT);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept && is_sample) begin
      if (block_end) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_add;
        count <= count_inc;
      end
    end
  end

endmodule

// ----- rtl/vlmk_queue.sv -----
// Short queue of finished blocks waiting for the meter divider.
module vlmk_queue import vlmk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  block_job_t push_job,
  input  logic       pop,
  output block_job_t pop_job,
  output logic       full,
  output logic       empty
);

  block_job_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full    = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/vlmk_back.sv -----
// Back end: restoring divider for the block meter and the frame peak register.
module vlmk_back import vlmk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  block_job_t         q_job,
  input  logic               peak_clear,
  output logic               q_pop,
  output logic               busy,
  output logic [LEVEL_W-1:0] frame_peak
);

  div_state_t          state;
  div_state_t          state_next;
  block_job_t          job_r;
  logic [REM_W-1:0]    rem;
  logic [DVS_W-1:0]    dvs;
  logic [DVS_W+6:0]    dsh;
  logic [QUOT_W-1:0]   quot;
  logic [STEP_W-1:0]   step;
  logic [DEN_W-1:0]    den;
  logic                sat;
  logic                ge;

  // 640 * count as two shifted copies.
  assign den = DEN_W'({job_r.count, 9'b0}) + DEN_W'({job_r.count, 7'b0});
  // Any quotient of 256 or more reads as full scale.
  assign sat = rem >= REM_W'({dvs, 8'b0});
  assign ge  = rem >= REM_W'(dsh);

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE:  if (!q_empty) state_next = DIV_LOAD;
      DIV_LOAD:  state_next = DIV_CHECK;
      DIV_CHECK: state_next = sat ? DIV_DONE : DIV_STEP;
      DIV_STEP:  if (step == '0) state_next = DIV_DONE;
      DIV_DONE:  state_next = DIV_IDLE;
      default:   state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    busy  = 1'b1;
    case (state)
      DIV_IDLE: begin
        q_pop = !q_empty;
        busy  = 1'b0;
      end
      default: begin
        q_pop = 1'b0;
        busy  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (q_pop) begin
          job_r <= q_job;
        end
      end
      DIV_LOAD: begin
        rem <= REM_W'({job_r.sum, 1'b0}) + REM_W'(den);
        dvs <= {den, 1'b0};
      end
      DIV_CHECK: begin
        quot <= sat ? '1 : '0;
        dsh  <= {dvs, 7'b0};
        step <= STEP_W'(QUOT_W - 1);
      end
      DIV_STEP: begin
        if (ge) begin
          rem <= rem - REM_W'(dsh);
        end
        quot <= {quot[QUOT_W-2:0], ge};
        dsh  <= dsh >> 1;
        step <= step - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_peak <= '0;
    end else if (peak_clear) begin
      frame_peak <= '0;
    end else if ((state == DIV_DONE) && (quot > frame_peak)) begin
      frame_peak <= quot;
    end
  end

endmodule

// ----- rtl/vlmk_keyer.sv -----
// Keyer: frame meter level, attack and decay timers, push-to-talk latch.
module vlmk_keyer import vlmk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  item_cmd_t          cmd,
  input  logic [LEVEL_W-1:0] frame_peak,
  input  logic               vox_enable,
  input  logic [LEVEL_W-1:0] voice_threshold,
  input  logic [MS_W-1:0]    attack_ms,
  input  logic [MS_W-1:0]    decay_ms,
  input  logic               timer_clear,
  output result_t            res_next
);

  logic               keyed;
  logic               keyed_next;
  logic               ptt_latched;
  logic               ptt_latched_next;
  logic [TIMER_W-1:0] attack_timer;
  logic [TIMER_W-1:0] attack_timer_next;
  logic [TIMER_W-1:0] decay_timer;
  logic [TIMER_W-1:0] decay_timer_next;
  logic [LEVEL_W-1:0] meter_level;
  logic [LEVEL_W-1:0] meter_level_next;
  logic [TIMER_W:0]   attack_sum;
  logic [TIMER_W:0]   decay_sum;
  logic [TIMER_W-1:0] attack_sat;
  logic [TIMER_W-1:0] decay_sat;
  logic               voice;

  assign attack_sum = {1'b0, attack_timer} + (TIMER_W+1)'(FRAME_MS);
  assign decay_sum  = {1'b0, decay_timer} + (TIMER_W+1)'(FRAME_MS);
  assign attack_sat = attack_sum[TIMER_W] ? '1 : attack_sum[TIMER_W-1:0];
  assign decay_sat  = decay_sum[TIMER_W] ? '1 : decay_sum[TIMER_W-1:0];
  assign voice      = frame_peak >= voice_threshold;

  always_comb begin
    keyed_next        = keyed;
    ptt_latched_next  = ptt_latched;
    attack_timer_next = attack_timer;
    decay_timer_next  = decay_timer;
    meter_level_next  = meter_level;
    if (timer_clear) begin
      attack_timer_next = '0;
      decay_timer_next  = '0;
    end
    if (cmd.tick) begin
      meter_level_next = frame_peak;
      if (vox_enable) begin
        if (!keyed) begin
          if (voice) begin
            attack_timer_next = attack_sat;
            if (attack_sat >= TIMER_W'(attack_ms)) begin
              attack_timer_next = '0;
              decay_timer_next  = '0;
              keyed_next        = 1'b1;
            end
          end else begin
            attack_timer_next = '0;
          end
        end else begin
          if (!voice) begin
            decay_timer_next = decay_sat;
            if (decay_sat >= TIMER_W'(decay_ms)) begin
              decay_timer_next  = '0;
              attack_timer_next = '0;
              // The push-to-talk latch holds the key against decay.
              if (!ptt_latched) begin
                keyed_next = 1'b0;
              end
            end
          end else begin
            decay_timer_next = '0;
          end
        end
      end
    end
    if (cmd.ptt) begin
      if (keyed) begin
        keyed_next        = 1'b0;
        ptt_latched_next  = 1'b0;
        attack_timer_next = '0;
        decay_timer_next  = '0;
      end else begin
        keyed_next       = 1'b1;
        ptt_latched_next = 1'b1;
      end
    end
  end

  assign res_next.key_on = keyed_next;
  assign res_next.meter  = meter_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      keyed        <= 1'b0;
      ptt_latched  <= 1'b0;
      attack_timer <= '0;
      decay_timer  <= '0;
      meter_level  <= '0;
    end else begin
      keyed        <= keyed_next;
      ptt_latched  <= ptt_latched_next;
      attack_timer <= attack_timer_next;
      decay_timer  <= decay_timer_next;
      meter_level  <= meter_level_next;
    end
  end

endmodule

// ----- rtl/vox_level_meter_keyer.sv -----
// Top level of the VOX level meter keyer: configuration, datapath halves and result register.
// Every item gives one result beat with the key state and frame meter after that item.
// Audio samples and push-to-talk presses are taken one per cycle as long as the result
// register drains. A sample that ends a block queues that block for a shared restoring
// divider, which takes one block at a time, with a shorter path when the meter saturates;
// the queue holds two blocks, and a block end stalls the input while the queue is full.
// A frame tick is held until the queue is empty and the divider is idle, so that it sees
// every block that ended before it.
// Configuration may be written at any time the block is idle; there is no reset sweep.
module vox_level_meter_keyer import vlmk_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 func,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       block_last,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       key_on,
  output logic [LEVEL_W-1:0]         meter
);

  logic               vox_enable;
  logic [LEVEL_W-1:0] voice_threshold;
  logic [MS_W-1:0]    attack_ms;
  logic [MS_W-1:0]    decay_ms;
  logic [GAIN_W-1:0]  mic_gain_tenths;

  logic               out_free;
  logic               accept;
  item_cmd_t          cmd;
  logic               job_push;
  block_job_t         job;
  block_job_t         q_job;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic               back_busy;
  logic               back_pending;
  logic [LEVEL_W-1:0] frame_peak;
  logic               timer_clear;
  result_t            res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vox_enable      <= 1'b0;
      voice_threshold <= LEVEL_W'(10);
      attack_ms       <= MS_W'(500);
      decay_ms        <= MS_W'(1000);
      mic_gain_tenths <= GAIN_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOX_ENABLE: vox_enable      <= cfg_data[0];
        REG_VOX_LEVEL:  voice_threshold <= cfg_data[LEVEL_W-1:0];
        REG_ATTACK_MS:  attack_ms       <= cfg_data[MS_W-1:0];
        REG_DECAY_MS:   decay_ms        <= cfg_data[MS_W-1:0];
        REG_MIC_GAIN:   mic_gain_tenths <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign timer_clear  = cfg_we && (cfg_index == REG_VOX_ENABLE);
  assign out_free     = !result_valid || !result_stall;
  assign back_pending = back_busy || !q_empty;

  vlmk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .func         (func),
    .sample       (sample),
    .block_last   (block_last),
    .gain         (mic_gain_tenths),
    .out_free     (out_free),
    .q_full       (q_full),
    .back_pending (back_pending),
    .item_stall   (item_stall),
    .accept       (accept),
    .cmd          (cmd),
    .job_push     (job_push),
    .job          (job)
  );

  vlmk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .pop_job  (q_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  vlmk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .peak_clear (cmd.tick),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .frame_peak (frame_peak)
  );

  vlmk_keyer u_keyer (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .frame_peak      (frame_peak),
    .vox_enable      (vox_enable),
    .voice_threshold (voice_threshold),
    .attack_ms       (attack_ms),
    .decay_ms        (decay_ms),
    .timer_clear     (timer_clear),
    .res_next        (res_next)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      key_on <= res_next.key_on;
      meter  <= res_next.meter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // A frame tick only goes through once every ended block has been measured.
  assert property (@(posedge clk) disable iff (rst)
    cmd.tick |-> (q_empty && !back_busy))
    else $error("frame tick accepted with block meters still pending");

  // The block queue never takes a block while it is full.
  assert property (@(posedge clk) disable iff (rst)
    job_push |-> !q_full)
    else $error("block queue overflow");

  // Every accepted item leaves a result beat in the output register.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result beat");

  // The divider only starts a block when one is queued.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("divider popped an empty queue");
`endif

endmodule
